### sv/sprite_depth_sort_defines.svh
// Assertion macros for the sprite depth sorter.
// The asserting scope must provide clk and rst_n.
`ifndef SPRITE_DEPTH_SORT_DEFINES_SVH
`define SPRITE_DEPTH_SORT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sds_pkg.sv
package sds_pkg;

    localparam int MAX_SPRITES_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;

    localparam int COORD_FIELD_W = 16;
    localparam int INDEX_FIELD_W = 6;
    localparam int DIST_FIELD_W  = 33;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_FRAME  = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [COORD_FIELD_W-1:0] coord_x;
        logic [COORD_FIELD_W-1:0] coord_y;
    } in_t;

    typedef struct packed {
        logic [INDEX_FIELD_W-1:0] sprite_index;
        logic [DIST_FIELD_W-1:0]  distance;
        logic                     last;
    } out_t;

    // Work memory read address source
    typedef enum logic [1:0] {
        RD_I,
        RD_I1,
        RD_J,
        RD_J1
    } rd_sel_t;

    typedef struct packed {
        logic    clear_count;
        logic    append;
        logic    capture;
        logic    pos_rd;
        logic    calc_diff;
        logic    calc_sq;
        logic    dist_wr;
        logic    i_clear;
        logic    i_inc;
        logic    j_clear;
        logic    j_inc;
        logic    j_from_i;
        logic    work_rd;
        rd_sel_t rd_sel;
        logic    load_holder;
        logic    cmp_step;
        logic    store_holder;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic n_one;
        logic j_last;
        logic i_last;
        logic out_free;
    } sts_t;

endpackage

### sv/sds_ram.sv
module sds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/sds_ctrl.sv
module sds_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   opcode,
    input  sds_pkg::sts_t sts,
    output sds_pkg::cmd_t cmd
);

    import sds_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b00000000001,
        ST_D_RD    = 11'b00000000010,
        ST_D_SUB   = 11'b00000000100,
        ST_D_MUL   = 11'b00000001000,
        ST_D_WR    = 11'b00000010000,
        ST_S_START = 11'b00000100000,
        ST_S_LOAD  = 11'b00001000000,
        ST_S_CMP   = 11'b00010000000,
        ST_S_STORE = 11'b00100000000,
        ST_E_START = 11'b01000000000,
        ST_E_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (opcode)
                        OP_CLEAR:  cmd.clear_count = 1'b1;
                        OP_APPEND: cmd.append = 1'b1;
                        OP_FRAME:
                        begin
                            if (!sts.count_zero)
                            begin
                                cmd.capture = 1'b1;
                                cmd.j_clear = 1'b1;
                                state_next  = ST_D_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_D_RD:
            begin
                cmd.pos_rd = 1'b1;
                state_next = ST_D_SUB;
            end
            ST_D_SUB:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = ST_D_MUL;
            end
            ST_D_MUL:
            begin
                cmd.calc_sq = 1'b1;
                state_next  = ST_D_WR;
            end
            ST_D_WR:
            begin
                cmd.dist_wr = 1'b1;
                if (!sts.j_last)
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = ST_D_RD;
                end
                else if (sts.n_one)
                begin
                    // single sprite: nothing to sort, read it back for output
                    cmd.j_clear = 1'b1;
                    state_next  = ST_S_STORE;
                end
                else
                begin
                    cmd.i_clear = 1'b1;
                    state_next  = ST_S_START;
                end
            end
            ST_S_START:
            begin
                cmd.work_rd = 1'b1;
                cmd.rd_sel  = RD_I;
                state_next  = ST_S_LOAD;
            end
            ST_S_LOAD:
            begin
                cmd.load_holder = 1'b1;
                cmd.j_from_i    = 1'b1;
                cmd.work_rd     = 1'b1;
                cmd.rd_sel      = RD_I1;
                state_next      = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (sts.j_last)
                begin
                    state_next = ST_S_STORE;
                end
                else
                begin
                    cmd.j_inc   = 1'b1;
                    cmd.work_rd = 1'b1;
                    cmd.rd_sel  = RD_J1;
                end
            end
            ST_S_STORE:
            begin
                if (sts.n_one)
                begin
                    cmd.work_rd = 1'b1;
                    cmd.rd_sel  = RD_J;
                    state_next  = ST_E_OUT;
                end
                else
                begin
                    cmd.store_holder = 1'b1;
                    if (sts.i_last)
                    begin
                        cmd.j_clear = 1'b1;
                        state_next  = ST_E_START;
                    end
                    else
                    begin
                        cmd.i_inc   = 1'b1;
                        cmd.work_rd = 1'b1;
                        cmd.rd_sel  = RD_I1;
                        state_next  = ST_S_LOAD;
                    end
                end
            end
            ST_E_START:
            begin
                // read entry 0 once the final holder write has landed
                cmd.work_rd = 1'b1;
                cmd.rd_sel  = RD_J;
                state_next  = ST_E_OUT;
            end
            ST_E_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.j_inc   = 1'b1;
                        cmd.work_rd = 1'b1;
                        cmd.rd_sel  = RD_J1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/sds_dpath.sv
module sds_dpath #(
    parameter int MAX_SPRITES = sds_pkg::MAX_SPRITES_DEF,
    parameter int COORD_BITS  = sds_pkg::COORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  sds_pkg::in_t  in_data,
    input  sds_pkg::cmd_t cmd,
    output sds_pkg::sts_t sts,
    output logic          out_valid,
    input  logic          out_ready,
    output sds_pkg::out_t out_data
);

    import sds_pkg::*;

    localparam int CW    = (COORD_BITS < COORD_FIELD_W) ? COORD_BITS : COORD_FIELD_W;
    localparam int SQW   = 2 * CW;
    localparam int DW    = SQW + 1;
    localparam int IW    = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
    localparam int CNT_W = $clog2(MAX_SPRITES + 1);
    localparam int WW    = DW + IW;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [CW-1:0]    player_x_reg, player_y_reg;
    logic [CW-1:0]    dx_reg, dy_reg;
    logic [SQW-1:0]   sqx_reg, sqy_reg;
    logic [DW-1:0]    holder_dist_reg;
    logic [IW-1:0]    holder_idx_reg;
    logic             out_valid_reg, out_valid_next;
    out_t             out_data_reg;

    logic             full;
    logic             pos_wr;
    logic [2*CW-1:0]  pos_rd_data;
    logic [CW-1:0]    sprite_x, sprite_y;

    logic             work_wr;
    logic [IW-1:0]    work_wr_addr;
    logic [WW-1:0]    work_wr_data;
    logic [IW-1:0]    work_rd_addr;
    logic [WW-1:0]    work_rd_data;
    logic [DW-1:0]    rd_dist;
    logic [IW-1:0]    rd_idx;
    logic             swap;

    assign full   = (count_reg == CNT_W'(MAX_SPRITES));
    assign pos_wr = cmd.append && !full;

    sds_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_SPRITES)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_wr),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data ({in_data.coord_x[CW-1:0], in_data.coord_y[CW-1:0]}),
        .rd_en   (cmd.pos_rd),
        .rd_addr (j_reg),
        .rd_data (pos_rd_data)
    );

    assign sprite_x = pos_rd_data[2*CW-1:CW];
    assign sprite_y = pos_rd_data[CW-1:0];

    assign rd_dist = work_rd_data[WW-1:IW];
    assign rd_idx  = work_rd_data[IW-1:0];
    assign swap    = holder_dist_reg < rd_dist;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_I:    work_rd_addr = i_reg;
            RD_I1:   work_rd_addr = i_reg + IW'(1);
            RD_J:    work_rd_addr = j_reg;
            RD_J1:   work_rd_addr = j_reg + IW'(1);
            default: work_rd_addr = j_reg;
        endcase
    end

    // Write port: distance fill, swap during the inner pass, holder write-back
    always_comb
    begin
        work_wr      = 1'b0;
        work_wr_addr = j_reg;
        work_wr_data = {holder_dist_reg, holder_idx_reg};
        if (cmd.dist_wr)
        begin
            work_wr      = 1'b1;
            work_wr_data = {DW'(sqx_reg) + DW'(sqy_reg), j_reg};
        end
        else if (cmd.cmp_step)
        begin
            work_wr = swap;
        end
        else if (cmd.store_holder)
        begin
            work_wr      = 1'b1;
            work_wr_addr = i_reg;
        end
    end

    sds_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_SPRITES)
    ) u_work_ram (
        .clk     (clk),
        .wr_en   (work_wr),
        .wr_addr (work_wr_addr),
        .wr_data (work_wr_data),
        .rd_en   (cmd.work_rd),
        .rd_addr (work_rd_addr),
        .rd_data (work_rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (pos_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        i_next = i_reg;
        if (cmd.i_clear)
        begin
            i_next = '0;
        end
        else if (cmd.i_inc)
        begin
            i_next = i_reg + IW'(1);
        end

        j_next = j_reg;
        if (cmd.j_clear)
        begin
            j_next = '0;
        end
        else if (cmd.j_from_i)
        begin
            j_next = i_reg + IW'(1);
        end
        else if (cmd.j_inc)
        begin
            j_next = j_reg + IW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            player_x_reg <= in_data.coord_x[CW-1:0];
            player_y_reg <= in_data.coord_y[CW-1:0];
        end
        if (cmd.calc_diff)
        begin
            dx_reg <= (player_x_reg >= sprite_x) ? player_x_reg - sprite_x
                                                 : sprite_x - player_x_reg;
            dy_reg <= (player_y_reg >= sprite_y) ? player_y_reg - sprite_y
                                                 : sprite_y - player_y_reg;
        end
        if (cmd.calc_sq)
        begin
            sqx_reg <= SQW'(dx_reg) * SQW'(dx_reg);
            sqy_reg <= SQW'(dy_reg) * SQW'(dy_reg);
        end
        if (cmd.load_holder || (cmd.cmp_step && swap))
        begin
            holder_dist_reg <= rd_dist;
            holder_idx_reg  <= rd_idx;
        end
        if (cmd.out_load)
        begin
            out_data_reg.sprite_index <= INDEX_FIELD_W'(rd_idx);
            out_data_reg.distance     <= DIST_FIELD_W'(rd_dist);
            out_data_reg.last         <= sts.j_last;
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.n_one      = (count_reg == CNT_W'(1));
    assign sts.j_last     = ((CNT_W'(j_reg) + CNT_W'(1)) == count_reg);
    assign sts.i_last     = ((CNT_W'(i_reg) + CNT_W'(2)) == count_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### sv/sprite_depth_sort.sv
// Clear and append requests keep the block idle, so the next request is taken the
// cycle after. A frame request over n sprites holds off input while it runs a distance
// step per sprite (read, subtract, square, write), one compare per sorting pair on the
// single work-memory read port plus a load and a store per sort row, and then emits the
// results in order, holding each one while the receiver stalls.
// Reset clears the sprite count and the output valid; the position and work memories
// are not cleared and need no clearing pass.
module sprite_depth_sort #(
    parameter int MAX_SPRITES = sds_pkg::MAX_SPRITES_DEF,
    parameter int COORD_BITS  = sds_pkg::COORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sds_pkg::in_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output sds_pkg::out_t out_data
);

    import sds_pkg::*;

    // Controller: sequences the distance pass, the exchange sort and the emit pass.
    // The sort keeps entry i in a holder register and streams entries j past it,
    // writing the displaced holder back to j on each swap.
    cmd_t cmd;
    sts_t sts;

    sds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (in_data.opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: sprite table, distance unit, work memory and the output register.
    // The output register lets the last result of a frame wait while the next
    // request is taken.
    sds_dpath #(
        .MAX_SPRITES (MAX_SPRITES),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### sv/sds_checker.sv
`include "sprite_depth_sort_defines.svh"

module sds_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input sds_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input sds_pkg::out_t out_data
);

    import sds_pkg::*;

    // A stalled result holds
    `SDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")

    // Input stalls only after a frame request is taken
    `SDS_ASSERT_SAME(a_stall_by_frame, $fell(in_ready), $past(in_valid) && ($past(in_data.opcode) == OP_FRAME), "input stalled without a frame request")

    // A pending result that is not the last keeps input stalled
    `SDS_ASSERT_SAME(a_run_open, out_valid && !out_data.last, !in_ready, "request taken inside an open result run")

    // New results appear only while a frame is being worked
    `SDS_ASSERT_SAME(a_result_in_frame, $rose(out_valid), !$past(in_ready), "result appeared outside a frame")

endmodule

bind sprite_depth_sort sds_checker u_sds_checker (.*);

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sds_pkg::*;

    // Opcode 3 has no meaning; the block must drop such a request.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int TABLE_DEPTH    = MAX_SPRITES_DEF;
    localparam int REQUEST_TARGET = 270;
    // A full 64-sprite frame keeps both channels quiet through its distance and sort
    // passes before its first result. Allow that with a wide margin plus the longest stall.
    localparam int QUIET_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = 64;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    // Predictor copy of the sprite table.
    logic [COORD_FIELD_W-1:0] sprite_x [TABLE_DEPTH];
    logic [COORD_FIELD_W-1:0] sprite_y [TABLE_DEPTH];
    int                       sprite_total;

    // Far-to-near results still owed by the block, oldest first.
    out_t expected_order [$];

    int  mismatch_count;
    int  requests_sent;
    int  frames_sorted;
    int  results_seen;
    // Raise to run both channels at full rate.
    bit  no_idle;

    sprite_depth_sort dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Update the sprite table for one accepted request and, on a frame,
    // queue the sorted run: squared distances, then an exchange sort that
    // swaps pair (i, j), i < j, whenever distance i is below distance j.
    task automatic apply_request(input in_t req);
        longint unsigned sq_dist [TABLE_DEPTH];
        int              idx  [TABLE_DEPTH];
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned hold_dist;
        int              hold_idx;
        out_t            want;
        case (req.opcode)
            OP_CLEAR:
                sprite_total = 0;
            OP_APPEND:
                // Drop appends to a full table.
                if (sprite_total < TABLE_DEPTH)
                begin
                    sprite_x[sprite_total] = req.coord_x;
                    sprite_y[sprite_total] = req.coord_y;
                    sprite_total++;
                end
            OP_FRAME:
                if (sprite_total > 0)
                begin
                    frames_sorted++;
                    for (int k = 0; k < sprite_total; k++)
                    begin
                        dx = (sprite_x[k] >= req.coord_x) ? sprite_x[k] - req.coord_x
                                                          : req.coord_x - sprite_x[k];
                        dy = (sprite_y[k] >= req.coord_y) ? sprite_y[k] - req.coord_y
                                                          : req.coord_y - sprite_y[k];
                        sq_dist[k] = dx * dx + dy * dy;
                        idx[k]     = k;
                    end
                    for (int i = 0; i + 1 < sprite_total; i++)
                        for (int j = i + 1; j < sprite_total; j++)
                            if (sq_dist[i] < sq_dist[j])
                            begin
                                hold_dist  = sq_dist[i];
                                hold_idx   = idx[i];
                                sq_dist[i] = sq_dist[j];
                                idx[i]     = idx[j];
                                sq_dist[j] = hold_dist;
                                idx[j]     = hold_idx;
                            end
                    for (int k = 0; k < sprite_total; k++)
                    begin
                        want.sprite_index = idx[k][INDEX_FIELD_W-1:0];
                        want.distance     = sq_dist[k][DIST_FIELD_W-1:0];
                        want.last         = (k == sprite_total - 1);
                        expected_order.push_back(want);
                    end
                end
            default:
                ;
        endcase
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Corners show up often so that zero and all-ones coordinates recur.
    function automatic logic [COORD_FIELD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return COORD_FIELD_W'($urandom);
        endcase
    endfunction

    // Present one request and hold it until accepted. Valid is left high
    // afterwards so a following request can go out on the very next edge.
    task automatic send_request(input logic [1:0] op, input logic [COORD_FIELD_W-1:0] x,
                                input logic [COORD_FIELD_W-1:0] y);
        in_t req;
        int  gap;
        req.opcode  = op;
        req.coord_x = x;
        req.coord_y = y;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
        apply_request(req);
    endtask

    // Hold off the sender until every owed result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_order.size() > 0)
            @(posedge clk);
    endtask

    task automatic append_random_sprites(input int count);
        for (int k = 0; k < count; k++)
            send_request(OP_APPEND, pick_coord(), pick_coord());
    endtask

    // Frames on an empty table and the unused opcode must produce nothing.
    task automatic test_empty_table();
        send_request(OP_FRAME, pick_coord(), pick_coord());
        send_request(OP_UNUSED, '1, '1);
        send_request(OP_CLEAR, '1, '1);
        send_request(OP_FRAME, '0, '0);
        drain_results();
    endtask

    // One sprite against the corners: zero distance and the largest distance.
    task automatic test_single_sprite();
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_APPEND, '0, '0);
        send_request(OP_FRAME, '1, '1);
        send_request(OP_FRAME, '0, '0);
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_APPEND, '1, '0);
        send_request(OP_FRAME, '0, '1);
        send_request(OP_FRAME, '1, '0);
        drain_results();
    endtask

    // Equal distances and duplicate positions pin down the swap order.
    task automatic test_tied_distances();
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_APPEND, 16'h0100, 16'h0100);
        send_request(OP_APPEND, 16'h0300, 16'h0100);
        send_request(OP_UNUSED, 16'h0500, 16'h0500);
        send_request(OP_APPEND, 16'h0100, 16'h0300);
        send_request(OP_APPEND, 16'h0100, 16'h0100);
        send_request(OP_APPEND, 16'h8000, 16'h8000);
        send_request(OP_APPEND, 16'h0300, 16'h0100);
        send_request(OP_FRAME, 16'h0100, 16'h0100);
        send_request(OP_FRAME, 16'h8000, 16'h8000);
        drain_results();
    endtask

    // Fill the table, push two more appends that must be dropped, then sort
    // the full table once at full rate and once under receiver stalls.
    task automatic test_full_table();
        no_idle = 1'b1;
        send_request(OP_CLEAR, '0, '0);
        append_random_sprites(TABLE_DEPTH + 2);
        send_request(OP_FRAME, pick_coord(), pick_coord());
        drain_results();
        no_idle = 1'b0;
        send_request(OP_FRAME, pick_coord(), pick_coord());
        drain_results();
    endtask

    // Mostly well-formed load-and-sort sequences with random content;
    // the rest is random requests of any opcode and pauses to drain.
    task automatic test_random_traffic();
        int roll;
        int count;
        while (requests_sent < REQUEST_TARGET)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 9);
            if (roll < 7)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_request(OP_CLEAR, pick_coord(), pick_coord());
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    count = $urandom_range(1, 8);
                else if (roll < 95)
                    count = $urandom_range(9, 24);
                else
                    count = $urandom_range(40, 70);
                append_random_sprites(count);
                repeat ($urandom_range(1, 3))
                    send_request(OP_FRAME, pick_coord(), pick_coord());
            end
            else if (roll < 9)
            begin
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), pick_coord(), pick_coord());
            end
            else
                drain_results();
        end
        no_idle = 1'b0;
    endtask

    // Receiver: hold each ready level for a random stretch, mostly short,
    // with an occasional long stall; run at full rate while no_idle is set.
    initial
    begin
        int hold_left;
        int roll;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (no_idle)
                out_ready <= 1'b1;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    out_ready <= 1'b1;
                    hold_left = $urandom_range(0, 6);
                end
                else if (roll < 92)
                begin
                    out_ready <= 1'b0;
                    hold_left = $urandom_range(0, 3);
                end
                else
                begin
                    out_ready <= 1'b0;
                    hold_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // Compare every accepted result with the oldest owed one.
    always @(posedge clk)
    begin : check_result
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_order.size() == 0)
            begin
                $error("unexpected result: sprite_index %0d distance %0d last %0b",
                       out_data.sprite_index, out_data.distance, out_data.last);
                mismatch_count++;
            end
            else
            begin
                want = expected_order.pop_front();
                if (out_data.sprite_index !== want.sprite_index)
                begin
                    $error("sprite_index: expected %0d, got %0d",
                           want.sprite_index, out_data.sprite_index);
                    mismatch_count++;
                end
                if (out_data.distance !== want.distance)
                begin
                    $error("distance: expected %0d, got %0d",
                           want.distance, out_data.distance);
                    mismatch_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, out_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        no_idle        = 1'b0;
        sprite_total   = 0;
        mismatch_count = 0;
        requests_sent  = 0;
        frames_sorted  = 0;
        results_seen   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_single_sprite();
        test_tied_distances();
        test_full_table();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d non-empty frames sorted, %0d results checked",
                 requests_sent, frames_sorted, results_seen);
        $display("covered empty and full tables, dropped appends, ties and corner positions");
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/sds_pkg.sv
sv/sds_ram.sv
sv/sds_ctrl.sv
sv/sds_dpath.sv
sv/sprite_depth_sort.sv
sv/sds_checker.sv
test/testbench.sv
